>>> hw/rtl/vmme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmme_pkg
// Shared types and constants of the voice mixer with mu-law encoder: fill
// state machine codes, register indexes and the segment table of the mu-law
// ROM.
// ----------------------------------------------------------------------------
package vmme_pkg;

    localparam int ROM_DEPTH = 8192;
    localparam int ROM_AW    = 13;
    localparam int SEG_COUNT = 16;

    localparam logic REG_USE_MULAW = 1'b0;

    typedef enum logic [1:0] {
        FILL_SEG,
        FILL_ZERO,
        RUN
    } fsm_state_t;

    // per segment: value = start +/- (floor(p*(i+b)/q) - floor(p*b/q))
    // r0 is p*b mod q, down selects a falling segment
    typedef struct packed {
        logic [7:0]  start;
        logic [7:0]  stop;
        logic [3:0]  p;
        logic [10:0] q;
        logic [10:0] r0;
        logic        down;
    } seg_param_t;

    function automatic seg_param_t seg_param(input logic [3:0] seg);
        seg_param_t prm;
        case (seg)
            4'd0:    prm = '{8'd0,   8'd16,  4'd9,  11'd1157, 11'd8,  1'b0};
            4'd1:    prm = '{8'd16,  8'd32,  4'd15, 11'd964,  11'd4,  1'b0};
            4'd2:    prm = '{8'd32,  8'd48,  4'd15, 11'd482,  11'd0,  1'b0};
            4'd3:    prm = '{8'd48,  8'd64,  4'd14, 11'd225,  11'd13, 1'b0};
            4'd4:    prm = '{8'd64,  8'd80,  4'd1,  11'd8,    11'd0,  1'b0};
            4'd5:    prm = '{8'd80,  8'd96,  4'd1,  11'd4,    11'd0,  1'b0};
            4'd6:    prm = '{8'd96,  8'd112, 4'd9,  11'd19,   11'd8,  1'b0};
            4'd7:    prm = '{8'd112, 8'd127, 4'd1,  11'd1,    11'd0,  1'b0};
            4'd8:    prm = '{8'd255, 8'd239, 4'd1,  11'd1,    11'd0,  1'b1};
            4'd9:    prm = '{8'd239, 8'd223, 4'd1,  11'd2,    11'd0,  1'b1};
            4'd10:   prm = '{8'd223, 8'd207, 4'd1,  11'd4,    11'd0,  1'b1};
            4'd11:   prm = '{8'd207, 8'd191, 4'd13, 11'd105,  11'd12, 1'b1};
            4'd12:   prm = '{8'd191, 8'd175, 4'd14, 11'd225,  11'd13, 1'b1};
            4'd13:   prm = '{8'd175, 8'd159, 4'd7,  11'd225,  11'd6,  1'b1};
            4'd14:   prm = '{8'd159, 8'd143, 4'd4,  11'd257,  11'd2,  1'b1};
            4'd15:   prm = '{8'd143, 8'd127, 4'd2,  11'd257,  11'd0,  1'b1};
            default: prm = '{8'd0,   8'd16,  4'd9,  11'd1157, 11'd8,  1'b0};
        endcase
        return prm;
    endfunction

endpackage

>>> hw/rtl/vmme_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmme_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module vmme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/voice_mixer_mulaw_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_mixer_mulaw_encoder
// Sums one 16-bit sample per voice into a saturating accumulator and, on the
// frame's last voice, emits the clamped sum as a mu-law or 8-bit linear byte.
// ----------------------------------------------------------------------------
// After reset the block builds its 8192-entry mu-law table in RAM, one entry
// a cycle with a pause at each of the 16 segment ends and holds s_axis_tready
// low until the table is complete. From then on it takes one voice item every
// cycle while the output queue has room; the accumulator add and saturate are
// combinational in front of the sum register, so consecutive voices of a frame
// flow back to back. For the last voice the table read is registered beside
// the p1 stage registers, and the byte then goes into a three-entry output
// queue, which lets input keep flowing while a byte waits for m_axis_tready.
// ----------------------------------------------------------------------------
module voice_mixer_mulaw_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] voice_sample
    input  logic        s_axis_tlast,   // last_voice
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] QUEUE_LAST = 2'd2;
    localparam logic [1:0] QUEUE_FULL = 2'd3;

    vmme_pkg::fsm_state_t state_reg, state_next;

    logic [3:0]  seg_reg, seg_next;
    logic [7:0]  val_reg, val_next;
    logic [10:0] rem_reg, rem_next;
    logic [13:0] addr_reg, addr_next;
    logic [11:0] rem_sum;
    logic        seg_end;
    logic        seg_last;
    vmme_pkg::seg_param_t prm_cur;
    vmme_pkg::seg_param_t prm_nxt;

    logic        fill_we;
    logic [7:0]  fill_wdata;
    logic        run_mode;

    logic        use_mulaw_reg, use_mulaw_next;
    logic        cfg_wr;

    logic [19:0] mix_sum_reg, mix_sum_next;
    logic [20:0] sum_wide;
    logic [19:0] sum_sat;
    logic [15:0] sum_clamp;
    logic [15:0] sum_off;
    logic        in_accept;

    logic        p1_valid_reg, p1_valid_next;
    logic        p1_mulaw_reg;
    logic [7:0]  p1_lin_reg;
    logic [7:0]  rom_rdata;
    logic [7:0]  push_data;

    logic [7:0]  q_data_reg [3];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;
    logic [2:0]  occupancy;

    // mu-law table
    vmme_ram #(
        .WIDTH (8),
        .DEPTH (vmme_pkg::ROM_DEPTH)
    ) u_rom (
        .clk   (clk),
        .we    (fill_we),
        .waddr (addr_reg[vmme_pkg::ROM_AW-1:0]),
        .wdata (fill_wdata),
        .raddr (sum_off[15:3]),
        .rdata (rom_rdata)
    );

    // table fill sequencer
    always_comb
    begin
        prm_cur  = vmme_pkg::seg_param(seg_reg);
        prm_nxt  = vmme_pkg::seg_param(seg_reg + 4'd1);
        seg_end  = (val_reg == prm_cur.stop);
        seg_last = (seg_reg == 4'(vmme_pkg::SEG_COUNT - 1));
        rem_sum  = {1'b0, rem_reg} + {8'd0, prm_cur.p};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vmme_pkg::FILL_SEG:
            begin
                if (seg_end && seg_last)
                begin
                    state_next = vmme_pkg::FILL_ZERO;
                end
            end
            vmme_pkg::FILL_ZERO:
            begin
                if (addr_reg[13] || (addr_reg[12:0] == '1))
                begin
                    state_next = vmme_pkg::RUN;
                end
            end
            vmme_pkg::RUN:
            begin
                state_next = vmme_pkg::RUN;
            end
            default:
            begin
                state_next = vmme_pkg::RUN;
            end
        endcase
    end

    always_comb
    begin
        fill_we    = 1'b0;
        fill_wdata = val_reg;
        run_mode   = 1'b0;
        case (state_reg)
            vmme_pkg::FILL_SEG:
            begin
                fill_we = !seg_end && !addr_reg[13];
            end
            vmme_pkg::FILL_ZERO:
            begin
                fill_we    = !addr_reg[13];
                fill_wdata = 8'd0;
            end
            vmme_pkg::RUN:
            begin
                run_mode = 1'b1;
            end
            default:
            begin
                run_mode = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        seg_next  = seg_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        addr_next = addr_reg;
        if (state_reg == vmme_pkg::FILL_SEG)
        begin
            if (seg_end)
            begin
                if (!seg_last)
                begin
                    seg_next = seg_reg + 4'd1;
                    val_next = prm_nxt.start;
                    rem_next = prm_nxt.r0;
                end
            end
            else
            begin
                addr_next = addr_reg + 14'd1;
                if (rem_sum >= {1'b0, prm_cur.q})
                begin
                    rem_next = 11'(rem_sum - {1'b0, prm_cur.q});
                    val_next = prm_cur.down ? val_reg - 8'd1 : val_reg + 8'd1;
                end
                else
                begin
                    rem_next = rem_sum[10:0];
                end
            end
        end
        else if (state_reg == vmme_pkg::FILL_ZERO)
        begin
            addr_next = addr_reg + 14'd1;
        end
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == vmme_pkg::REG_USE_MULAW);

    always_comb
    begin
        use_mulaw_next = use_mulaw_reg;
        if (cfg_wr)
        begin
            use_mulaw_next = pwdata[0];
        end
        prdata = (paddr[2] == vmme_pkg::REG_USE_MULAW) ? {31'd0, use_mulaw_reg} : 32'd0;
    end

    // accumulate, saturate and clamp
    always_comb
    begin
        sum_wide = {mix_sum_reg[19], mix_sum_reg} + {{5{s_axis_tdata[15]}}, s_axis_tdata};
        if (sum_wide[20] != sum_wide[19])
        begin
            sum_sat = sum_wide[20] ? 20'h80000 : 20'h7FFFF;
        end
        else
        begin
            sum_sat = sum_wide[19:0];
        end
        if ((sum_sat[19:15] != 5'b00000) && (sum_sat[19:15] != 5'b11111))
        begin
            sum_clamp = sum_sat[19] ? 16'h8000 : 16'h7FFF;
        end
        else
        begin
            sum_clamp = sum_sat[15:0];
        end
        sum_off = sum_clamp ^ 16'h8000;
    end

    assign occupancy     = {1'b0, count_reg} + {2'd0, p1_valid_reg};
    assign s_axis_tready = run_mode && (occupancy <= {1'b0, QUEUE_LAST});
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        mix_sum_next  = mix_sum_reg;
        p1_valid_next = in_accept && s_axis_tlast;
        if (in_accept)
        begin
            mix_sum_next = s_axis_tlast ? 20'd0 : sum_sat;
        end
    end

    // output queue
    assign push          = p1_valid_reg;
    assign push_data     = p1_mulaw_reg ? rom_rdata : p1_lin_reg;
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = q_data_reg[rd_ptr_reg];
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_LAST) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_LAST) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        if (push && !pop && (count_reg != QUEUE_FULL))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vmme_pkg::FILL_SEG;
            seg_reg       <= 4'd0;
            val_reg       <= 8'd0;
            rem_reg       <= 11'd8;
            addr_reg      <= 14'd0;
            use_mulaw_reg <= 1'b1;
            mix_sum_reg   <= 20'd0;
            p1_valid_reg  <= 1'b0;
            wr_ptr_reg    <= 2'd0;
            rd_ptr_reg    <= 2'd0;
            count_reg     <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            val_reg       <= val_next;
            rem_reg       <= rem_next;
            addr_reg      <= addr_next;
            use_mulaw_reg <= use_mulaw_next;
            mix_sum_reg   <= mix_sum_next;
            p1_valid_reg  <= p1_valid_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p1_mulaw_reg <= use_mulaw_reg;
            p1_lin_reg   <= sum_off[15:8];
        end
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
